// ----- rtl/core/tss_pkg.sv -----
// ----------------------------------------------------------------------------
// tss_pkg: shared types and constants of the TCP send segmenter
// Flag codes, connection states, register indexes, word and control structs.
// ----------------------------------------------------------------------------
package tss_pkg;

   // TCP flag bits
   localparam logic [7:0] FL_FIN = 8'h01;
   localparam logic [7:0] FL_SYN = 8'h02;
   localparam logic [7:0] FL_RST = 8'h04;
   localparam logic [7:0] FL_ACK = 8'h10;

   // connection states, BSD order
   localparam logic [3:0] CS_CLOSED       = 4'd0;
   localparam logic [3:0] CS_LISTEN       = 4'd1;
   localparam logic [3:0] CS_SYN_SENT     = 4'd2;
   localparam logic [3:0] CS_SYN_RECEIVED = 4'd3;
   localparam logic [3:0] CS_ESTABLISHED  = 4'd4;
   localparam logic [3:0] CS_CLOSE_WAIT   = 4'd5;
   localparam logic [3:0] CS_FIN_WAIT_1   = 4'd6;
   localparam logic [3:0] CS_CLOSING      = 4'd7;
   localparam logic [3:0] CS_LAST_ACK     = 4'd8;
   localparam logic [3:0] CS_FIN_WAIT_2   = 4'd9;
   localparam logic [3:0] CS_TIME_WAIT    = 4'd10;

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SEG_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEND_SCALE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RECV_SCALE   = 2'd2;
   localparam int CSR_DATA_W = 16;

   localparam logic [15:0] MSS_RESET = 16'd1460;

   // width of the signed remaining-window arithmetic
   localparam int LW = 34;

   typedef struct packed {
      logic [31:0] unacked_seq;
      logic [31:0] next_seq;
      logic [31:0] max_seq;
      logic [16:0] queued_bytes;
      logic [3:0]  conn_state;
      logic [15:0] peer_window;
      logic [15:0] cong_window;
      logic [31:0] recv_next;
      logic [29:0] recv_space;
   } tss_req_type;

   typedef struct packed {
      logic        seg_valid;
      logic [31:0] seg_seq;
      logic [31:0] seg_ack;
      logic [7:0]  seg_flags;
      logic [16:0] payload_start;
      logic [15:0] payload_bytes;
      logic [15:0] window_field;
      logic [31:0] updated_next_seq;
      logic [31:0] updated_max_seq;
      logic        last;
   } tss_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WIDEN,
      ST_ALIGN,
      ST_BOUND,
      ST_EMIT
   } tss_state_type;

   typedef struct packed {
      logic load;
      logic widen;
      logic align;
      logic bound;
      logic emit_seg;
      logic emit_final;
   } tss_cmd_type;

   typedef struct packed {
      logic seg_go;
      logic out_free;
   } tss_stat_type;

   function automatic logic [7:0] state_flags(input logic [3:0] st);
      logic [7:0] f;
      unique case (st)
         CS_CLOSED:       f = FL_RST | FL_ACK;
         CS_LISTEN:       f = 8'h00;
         CS_SYN_SENT:     f = FL_SYN;
         CS_SYN_RECEIVED: f = FL_SYN | FL_ACK;
         CS_ESTABLISHED:  f = FL_ACK;
         CS_CLOSE_WAIT:   f = FL_ACK;
         CS_FIN_WAIT_1:   f = FL_FIN | FL_ACK;
         CS_CLOSING:      f = FL_FIN | FL_ACK;
         CS_LAST_ACK:     f = FL_FIN | FL_ACK;
         CS_FIN_WAIT_2:   f = FL_ACK;
         CS_TIME_WAIT:    f = FL_ACK;
         default:         f = 8'h00;
      endcase
      return f;
   endfunction

endpackage

// ----- rtl/core/tss_intf.sv -----
// ----------------------------------------------------------------------------
// tss channel interfaces
// Request, response and register-write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tss_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] unacked_seq;
   logic [31:0] next_seq;
   logic [31:0] max_seq;
   logic [16:0] queued_bytes;
   logic [3:0]  conn_state;
   logic [15:0] peer_window;
   logic [15:0] cong_window;
   logic [31:0] recv_next;
   logic [29:0] recv_space;

   modport source (output valid, unacked_seq, next_seq, max_seq, queued_bytes, conn_state,
                   peer_window, cong_window, recv_next, recv_space, input ready);
   modport sink (input valid, unacked_seq, next_seq, max_seq, queued_bytes, conn_state,
                 peer_window, cong_window, recv_next, recv_space, output ready);
endinterface

interface tss_rsp_if;
   logic        valid;
   logic        ready;
   logic        seg_valid;
   logic [31:0] seg_seq;
   logic [31:0] seg_ack;
   logic [7:0]  seg_flags;
   logic [16:0] payload_start;
   logic [15:0] payload_bytes;
   logic [15:0] window_field;
   logic [31:0] updated_next_seq;
   logic [31:0] updated_max_seq;
   logic        last;

   modport source (output valid, seg_valid, seg_seq, seg_ack, seg_flags, payload_start,
                   payload_bytes, window_field, updated_next_seq, updated_max_seq, last,
                   input ready);
   modport sink (input valid, seg_valid, seg_seq, seg_ack, seg_flags, payload_start,
                 payload_bytes, window_field, updated_next_seq, updated_max_seq, last,
                 output ready);
endinterface

interface tss_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/tcp_send_segmenter_core.sv -----
// ----------------------------------------------------------------------------
// tcp_send_segmenter_core: TCP output segmentation engine
// Turns one send opportunity into a burst of segment descriptor words.
// ----------------------------------------------------------------------------
// Operation: after a request is taken the sequencer runs the setup steps widen,
//   align and bound, then emits up to BURST segment words and a final word,
//   each one as the output register is free; a stalled sink holds the burst.
//   The final word frees the sequencer, and only then is the next request taken.
// Reset: synchronous, active high; clears sequencer, count and output valid,
//   loads max_seg_size 1460 and both scale shifts 0.
module tcp_send_segmenter_core #(
   parameter int BURST        = 8,
   parameter int TX_BUF_BYTES = 65536
) (
   input  logic         clock,
   input  logic         reset,
   tss_req_if.sink      req_ch,
   tss_rsp_if.source    rsp_ch,
   tss_csr_if.sink      csr_ch
);

   tss_pkg::tss_cmd_type  cmd;
   tss_pkg::tss_stat_type stat;
   tss_pkg::tss_req_type  req_word;
   tss_pkg::tss_rsp_type  rsp_word;
   logic                  rsp_valid;

   // register writes need no wait, so the write channel only holds off in reset
   assign csr_ch.ready = !reset;

   // gather the request word
   assign req_word.unacked_seq  = req_ch.unacked_seq;
   assign req_word.next_seq     = req_ch.next_seq;
   assign req_word.max_seq      = req_ch.max_seq;
   assign req_word.queued_bytes = req_ch.queued_bytes;
   assign req_word.conn_state   = req_ch.conn_state;
   assign req_word.peer_window  = req_ch.peer_window;
   assign req_word.cong_window  = req_ch.cong_window;
   assign req_word.recv_next    = req_ch.recv_next;
   assign req_word.recv_space   = req_ch.recv_space;

   // sequencer: setup steps, then one word per cycle while the sink takes them
   tss_ctrl #(
      .BURST (BURST)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // window math, segment sizing and the output word register
   tss_dpath #(
      .TX_BUF_BYTES (TX_BUF_BYTES)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_word  (req_word),
      .csr_valid (csr_ch.valid),
      .csr_index (csr_ch.index),
      .csr_data  (csr_ch.data),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   // drive the response channel from the output register
   assign rsp_ch.valid            = rsp_valid;
   assign rsp_ch.seg_valid        = rsp_word.seg_valid;
   assign rsp_ch.seg_seq          = rsp_word.seg_seq;
   assign rsp_ch.seg_ack          = rsp_word.seg_ack;
   assign rsp_ch.seg_flags        = rsp_word.seg_flags;
   assign rsp_ch.payload_start    = rsp_word.payload_start;
   assign rsp_ch.payload_bytes    = rsp_word.payload_bytes;
   assign rsp_ch.window_field     = rsp_word.window_field;
   assign rsp_ch.updated_next_seq = rsp_word.updated_next_seq;
   assign rsp_ch.updated_max_seq  = rsp_word.updated_max_seq;
   assign rsp_ch.last             = rsp_word.last;

endmodule

// ----- rtl/core/tss_ctrl.sv -----
// ----------------------------------------------------------------------------
// tss_ctrl: segmenter sequencer
// Steps one request through window setup, segment emission and final word.
// ----------------------------------------------------------------------------
module tss_ctrl #(
   parameter int BURST = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  tss_pkg::tss_stat_type stat,
   output tss_pkg::tss_cmd_type  cmd
);

   localparam int CW = $clog2(BURST + 1);

   tss_pkg::tss_state_type state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic                   more_seg;

   assign more_seg = stat.seg_go && (count_ff < CW'(BURST));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tss_pkg::ST_IDLE:  if (req_valid) state_in = tss_pkg::ST_WIDEN;
         tss_pkg::ST_WIDEN: state_in = tss_pkg::ST_ALIGN;
         tss_pkg::ST_ALIGN: state_in = tss_pkg::ST_BOUND;
         tss_pkg::ST_BOUND: state_in = tss_pkg::ST_EMIT;
         tss_pkg::ST_EMIT:  if (stat.out_free && !more_seg) state_in = tss_pkg::ST_IDLE;
         default:           state_in = tss_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         tss_pkg::ST_IDLE: begin
            // hold off requests while reset is applied
            req_ready = !reset;
            cmd.load  = req_valid && !reset;
         end
         tss_pkg::ST_WIDEN: cmd.widen = 1'b1;
         tss_pkg::ST_ALIGN: cmd.align = 1'b1;
         tss_pkg::ST_BOUND: cmd.bound = 1'b1;
         tss_pkg::ST_EMIT: begin
            cmd.emit_seg   = stat.out_free && more_seg;
            cmd.emit_final = stat.out_free && !more_seg;
         end
         default: cmd = '0;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.load) count_in = '0;
      else if (cmd.emit_seg) count_in = count_ff + CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tss_pkg::ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

endmodule

// ----- rtl/core/tss_dpath.sv -----
// ----------------------------------------------------------------------------
// tss_dpath: segmenter datapath
// Window arithmetic, per-segment length and flags, output word register.
// ----------------------------------------------------------------------------
module tss_dpath #(
   parameter int TX_BUF_BYTES = 65536
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tss_pkg::tss_cmd_type                 cmd,
   output tss_pkg::tss_stat_type                stat,
   input  tss_pkg::tss_req_type                 req_word,
   input  logic                                 csr_valid,
   input  logic [tss_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [tss_pkg::CSR_DATA_W-1:0]       csr_data,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output tss_pkg::tss_rsp_type                 rsp_word
);

   localparam int LW = tss_pkg::LW;

   // configuration
   logic [15:0] mss_ff;
   logic [3:0]  sscale_ff;
   logic [3:0]  rscale_ff;

   // captured request
   logic [31:0] una_ff, nxt_ff, mx_ff, ack_ff;
   logic [16:0] queued_ff;
   logic [3:0]  conn_ff;
   logic [15:0] pwin_ff, cwnd_ff;
   logic [29:0] rspace_ff;

   // prepared values
   logic [7:0]  base_flags_ff;
   logic [15:0] wfield_ff;
   logic [31:0] prod_ff;
   logic [30:0] shl_ff;
   logic [31:0] swnd_ff;
   logic [30:0] off_ff;
   logic [16:0] offs_ff;
   logic signed [LW-1:0] data_left_ff, win_left_ff, avail_left_ff;

   // output word
   logic                 rsp_valid_ff;
   tss_pkg::tss_rsp_type rsp_word_ff, rsp_word_in;

   // combinational
   logic [31:0] nxt_diff, nxt_raise, mx_diff;
   logic [16:0] queued_sat;
   logic [29:0] rshift;
   logic [15:0] wfield_sat;
   logic        fin;
   logic [17:0] seq_total;
   logic signed [LW-1:0] mss_s, winc, avail, len_s, inc_s;
   logic [15:0] seg_len;
   logic        fin_keep;
   logic [7:0]  seg_flags;
   logic [16:0] inc;
   logic [31:0] nxt_step, mx_step_diff, mx_step;

   always_ff @(posedge clock) begin
      if (reset) begin
         mss_ff    <= tss_pkg::MSS_RESET;
         sscale_ff <= '0;
         rscale_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            tss_pkg::CSR_MAX_SEG_SIZE: mss_ff    <= csr_data;
            tss_pkg::CSR_SEND_SCALE:   sscale_ff <= csr_data[3:0];
            tss_pkg::CSR_RECV_SCALE:   rscale_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // setup arithmetic
   assign nxt_diff   = nxt_ff - una_ff;
   assign nxt_raise  = nxt_diff[31] ? una_ff : nxt_ff;
   assign mx_diff    = mx_ff - nxt_ff;
   assign queued_sat = (32'(queued_ff) > 32'(TX_BUF_BYTES)) ? 17'(TX_BUF_BYTES) : queued_ff;
   assign rshift     = rspace_ff >> rscale_ff;
   assign wfield_sat = (|rshift[29:16]) ? 16'hFFFF : rshift[15:0];
   assign fin        = |(base_flags_ff & tss_pkg::FL_FIN);
   assign seq_total  = 18'(queued_ff) + 18'(fin);

   // per-segment arithmetic
   assign mss_s     = $signed(LW'(mss_ff));
   assign winc      = (win_left_ff > mss_s) ? mss_s : win_left_ff;
   assign avail     = avail_left_ff[LW-1] ? '0 : avail_left_ff;
   assign len_s     = (avail < winc) ? avail : winc;
   assign seg_len   = len_s[15:0];
   assign fin_keep  = fin && (avail_left_ff <= len_s);
   assign seg_flags = fin_keep ? base_flags_ff : (base_flags_ff & ~tss_pkg::FL_FIN);
   assign inc       = 17'(seg_len) + 17'(fin_keep);
   assign inc_s     = $signed(LW'(inc));
   assign nxt_step  = nxt_ff + 32'(inc);
   assign mx_step_diff = mx_ff - nxt_step;
   assign mx_step   = mx_step_diff[31] ? nxt_step : mx_ff;

   assign stat.seg_go   = (data_left_ff > 0) && (winc > 0);
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         una_ff    <= req_word.unacked_seq;
         nxt_ff    <= req_word.next_seq;
         mx_ff     <= req_word.max_seq;
         queued_ff <= req_word.queued_bytes;
         conn_ff   <= req_word.conn_state;
         pwin_ff   <= req_word.peer_window;
         cwnd_ff   <= req_word.cong_window;
         ack_ff    <= req_word.recv_next;
         rspace_ff <= req_word.recv_space;
      end else if (cmd.widen) begin
         nxt_ff        <= nxt_raise;
         queued_ff     <= queued_sat;
         base_flags_ff <= tss_pkg::state_flags(conn_ff);
         wfield_ff     <= wfield_sat;
         prod_ff       <= 32'(cwnd_ff) * 32'(mss_ff);
         shl_ff        <= 31'(pwin_ff) << sscale_ff;
      end else if (cmd.align) begin
         swnd_ff <= ({1'b0, shl_ff} < prod_ff) ? {1'b0, shl_ff} : prod_ff;
         off_ff  <= nxt_diff[30:0];
      end else if (cmd.bound) begin
         data_left_ff  <= $signed(LW'(seq_total)) - $signed(LW'(off_ff));
         win_left_ff   <= $signed(LW'(swnd_ff)) - $signed(LW'(off_ff));
         avail_left_ff <= $signed(LW'(queued_ff)) - $signed(LW'(off_ff));
         offs_ff       <= off_ff[16:0];
      end else if (cmd.emit_seg) begin
         nxt_ff        <= nxt_step;
         mx_ff         <= mx_step;
         offs_ff       <= offs_ff + inc;
         data_left_ff  <= data_left_ff - inc_s;
         win_left_ff   <= win_left_ff - inc_s;
         avail_left_ff <= avail_left_ff - inc_s;
      end
   end

   always_comb begin
      rsp_word_in = '0;
      if (cmd.emit_seg) begin
         rsp_word_in.seg_valid        = 1'b1;
         rsp_word_in.seg_seq          = nxt_ff;
         rsp_word_in.seg_ack          = ack_ff;
         rsp_word_in.seg_flags        = seg_flags;
         rsp_word_in.payload_start    = offs_ff;
         rsp_word_in.payload_bytes    = seg_len;
         rsp_word_in.window_field     = wfield_ff;
         rsp_word_in.updated_next_seq = nxt_step;
         rsp_word_in.updated_max_seq  = mx_step;
      end else begin
         rsp_word_in.updated_next_seq = nxt_ff;
         // raise send-max to send-next if it still lies behind
         rsp_word_in.updated_max_seq  = mx_diff[31] ? nxt_ff : mx_ff;
         rsp_word_in.last             = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_seg || cmd.emit_final) rsp_word_ff <= rsp_word_in;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.emit_seg || cmd.emit_final) rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// ----- tb/sv/tcp_send_segmenter_core_tb.sv -----
// ----------------------------------------------------------------------------
// tcp_send_segmenter_core_tb: self-checking bench for the TCP send segmenter
// Drives send opportunities through the request channel and programs the
// segment size and window scales over the register channel. Every request is
// turned into its expected burst of descriptor words by a local segmentation
// model, and each response word is compared field by field, in order.
// ----------------------------------------------------------------------------
module tcp_send_segmenter_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tss_pkg::*;

   localparam int BURST        = 8;
   localparam int TX_BUF_BYTES = 65536;

   // write index with no register behind it; the block must ignore it
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   // cycles with no handshake on any channel before the run is abandoned
   localparam int STALL_LIMIT = 3000;
   // the last word frees the sequencer; give it a few cycles anyway
   localparam int SETTLE_CYCLES = 8;

   logic clock;
   logic reset;

   tss_req_if req_if ();
   tss_rsp_if rsp_if ();
   tss_csr_if csr_if ();

   tcp_send_segmenter_core #(
      .BURST        (BURST),
      .TX_BUF_BYTES (TX_BUF_BYTES)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   // local copy of the register file, updated when a write is taken
   logic [15:0] seg_size_reg;
   logic [3:0]  send_shift_reg;
   logic [3:0]  recv_shift_reg;

   // descriptor words still owed by the block, oldest first
   tss_rsp_type pending_descriptors[$];

   int  mismatches;
   int  quiet_cycles;
   bit  sender_gaps;
   bit  receiver_stalls;
   int  hold_off_cycles;

   // ------------------------------------------------------------------------
   // clock and initial drive
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      // known values on every input before the first edge
      reset                <= 1'b1;
      req_if.valid         <= 1'b0;
      req_if.unacked_seq   <= '0;
      req_if.next_seq      <= '0;
      req_if.max_seq       <= '0;
      req_if.queued_bytes  <= '0;
      req_if.conn_state    <= '0;
      req_if.peer_window   <= '0;
      req_if.cong_window   <= '0;
      req_if.recv_next     <= '0;
      req_if.recv_space    <= '0;
      csr_if.valid         <= 1'b0;
      csr_if.index         <= '0;
      csr_if.data          <= '0;
   end

   // ------------------------------------------------------------------------
   // segmentation model
   // ------------------------------------------------------------------------

   // sequence-space comparison: a lies before b modulo 2^32
   function automatic bit seq_earlier(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return d[31];
   endfunction

   function automatic logic [7:0] flags_for_state(input logic [3:0] st);
      case (st)
         CS_CLOSED:       return FL_RST | FL_ACK;
         CS_LISTEN:       return 8'h00;
         CS_SYN_SENT:     return FL_SYN;
         CS_SYN_RECEIVED: return FL_SYN | FL_ACK;
         CS_ESTABLISHED,
         CS_CLOSE_WAIT,
         CS_FIN_WAIT_2,
         CS_TIME_WAIT:    return FL_ACK;
         CS_FIN_WAIT_1,
         CS_CLOSING,
         CS_LAST_ACK:     return FL_FIN | FL_ACK;
         default:         return 8'h00;
      endcase
   endfunction

   // Work out every descriptor word one send opportunity produces and queue
   // them behind the words already owed.
   function automatic void plan_segments(input tss_req_type r);
      logic [31:0] una, nxt, top, gap;
      logic [7:0]  base, flags;
      logic [63:0] wnd_field, peer_lim, cong_lim;
      longint      queued, fin, seq_total, offset, room, avail, len, send_wnd, seg_cap;
      int          count;
      bit          stop;
      tss_rsp_type w;

      una   = r.unacked_seq;
      nxt   = r.next_seq;
      top   = r.max_seq;
      queued = r.queued_bytes;
      if (queued > TX_BUF_BYTES) queued = TX_BUF_BYTES;
      base  = flags_for_state(r.conn_state);
      fin   = ((base & FL_FIN) != 0) ? 1 : 0;
      seg_cap = seg_size_reg;

      wnd_field = r.recv_space;
      wnd_field = wnd_field >> recv_shift_reg;
      if (wnd_field > 64'hFFFF) wnd_field = 64'hFFFF;

      peer_lim = r.peer_window;
      peer_lim = peer_lim << send_shift_reg;
      cong_lim = r.cong_window;
      cong_lim = cong_lim * seg_cap;
      send_wnd = (peer_lim < cong_lim) ? peer_lim : cong_lim;

      count = 0;
      stop  = 1'b0;
      while (count < BURST && !stop) begin
         if (seq_earlier(nxt, una)) nxt = una;
         seq_total = queued + fin;
         gap       = nxt - una;
         offset    = gap;
         if (seq_total - offset <= 0) begin
            stop = 1'b1;
         end else begin
            room = send_wnd - offset;
            if (room > seg_cap) room = seg_cap;
            if (room <= 0) begin
               stop = 1'b1;
            end else begin
               avail = queued - offset;
               if (avail < 0) avail = 0;
               len   = (avail < room) ? avail : room;
               flags = base;
               // FIN rides only on the segment that ends the queued data
               if (seq_total > offset + len + fin) flags = flags & ~FL_FIN;

               w = '0;
               w.seg_valid     = 1'b1;
               w.seg_seq       = nxt;
               w.seg_ack       = r.recv_next;
               w.seg_flags     = flags;
               w.payload_start = 17'(offset);
               w.payload_bytes = 16'(len);
               w.window_field  = 16'(wnd_field);

               nxt = nxt + 32'(len);
               if ((flags & FL_FIN) != 0) nxt = nxt + 32'd1;
               if (seq_earlier(top, nxt)) top = nxt;
               w.updated_next_seq = nxt;
               w.updated_max_seq  = top;
               pending_descriptors.push_back(w);
               count++;
            end
         end
      end

      if (seq_earlier(nxt, una)) nxt = una;
      if (seq_earlier(top, nxt)) top = nxt;
      w = '0;
      w.updated_next_seq = nxt;
      w.updated_max_seq  = top;
      w.last             = 1'b1;
      pending_descriptors.push_back(w);
   endfunction

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------

   // Present one opportunity and hold it until taken. Valid stays high on
   // return so a following request can go out back to back; quiesce() drops it.
   task automatic send_request(input tss_req_type r);
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.unacked_seq  <= r.unacked_seq;
      req_if.next_seq     <= r.next_seq;
      req_if.max_seq      <= r.max_seq;
      req_if.queued_bytes <= r.queued_bytes;
      req_if.conn_state   <= r.conn_state;
      req_if.peer_window  <= r.peer_window;
      req_if.cong_window  <= r.cong_window;
      req_if.recv_next    <= r.recv_next;
      req_if.recv_space   <= r.recv_space;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
      plan_segments(r);
   endtask

   // Drop valid, wait until every owed word is back, then let the block settle.
   task automatic quiesce();
      req_if.valid <= 1'b0;
      while (pending_descriptors.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // register side
   // ------------------------------------------------------------------------
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (!(csr_if.valid && csr_if.ready));
      case (idx)
         CSR_MAX_SEG_SIZE: seg_size_reg   = value;
         CSR_SEND_SCALE:   send_shift_reg = value[3:0];
         CSR_RECV_SCALE:   recv_shift_reg = value[3:0];
         default: ;
      endcase
   endtask

   // Program all three registers; scale writes carry junk in the unused bits.
   task automatic configure(input logic [15:0] seg_size, input logic [3:0] send_shift,
                            input logic [3:0] recv_shift);
      logic [15:0] junk;
      junk = 16'($urandom);
      write_register(CSR_MAX_SEG_SIZE, seg_size);
      write_register(CSR_SEND_SCALE, {junk[15:4], send_shift});
      junk = 16'($urandom);
      write_register(CSR_RECV_SCALE, {junk[15:4], recv_shift});
      csr_if.valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // stimulus builders
   // ------------------------------------------------------------------------
   function automatic tss_req_type make_request(
      input logic [31:0] una, input logic [31:0] nxt, input logic [31:0] top,
      input logic [16:0] queued, input logic [3:0] st, input logic [15:0] pwin,
      input logic [15:0] cwnd, input logic [31:0] ack, input logic [29:0] rspace);
      tss_req_type r;
      r.unacked_seq  = una;
      r.next_seq     = nxt;
      r.max_seq      = top;
      r.queued_bytes = queued;
      r.conn_state   = st;
      r.peer_window  = pwin;
      r.cong_window  = cwnd;
      r.recv_next    = ack;
      r.recv_space   = rspace;
      return r;
   endfunction

   // Mostly consistent sequence variables with random content, some noise.
   function automatic tss_req_type random_opportunity();
      tss_req_type r;
      int pick;
      r.unacked_seq = $urandom;
      r.next_seq    = $urandom;
      r.max_seq     = $urandom;
      r.recv_next   = $urandom;
      r.recv_space  = 30'($urandom);
      r.peer_window = 16'($urandom);
      r.cong_window = 16'($urandom);
      r.queued_bytes = 17'($urandom);
      r.conn_state  = 4'($urandom);
      if ($urandom_range(0, 99) < 15) return r;

      pick = $urandom_range(0, 19);
      if (pick < 14)      r.queued_bytes = 17'($urandom_range(0, 6000));
      else if (pick < 19) r.queued_bytes = 17'($urandom_range(0, TX_BUF_BYTES));
      else                r.queued_bytes = 17'($urandom_range(TX_BUF_BYTES + 1, 131071));

      r.next_seq = r.unacked_seq + $urandom_range(0, r.queued_bytes + 1);
      if ($urandom_range(0, 9) == 0) r.next_seq = r.unacked_seq - $urandom_range(1, 5000);
      r.max_seq = r.next_seq + $urandom_range(0, 3000);
      if ($urandom_range(0, 7) == 0) r.max_seq = r.next_seq - $urandom_range(1, 3000);

      pick = $urandom_range(0, 19);
      if (pick < 10)      r.conn_state = $urandom_range(0, 1) ? CS_ESTABLISHED : CS_CLOSE_WAIT;
      else if (pick < 15) r.conn_state = 4'(CS_FIN_WAIT_1 + $urandom_range(0, 2));

      if ($urandom_range(0, 4) != 0) r.peer_window = 16'($urandom_range(1000, 65535));
      if ($urandom_range(0, 4) != 0) r.cong_window = 16'($urandom_range(0, 12));
      if ($urandom_range(0, 1) != 0) r.recv_space  = 30'($urandom_range(0, 200000));
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // response side: random stalls, plus one long hold-off on request
   // ------------------------------------------------------------------------
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            // block the output long enough for the request side to back up
            rsp_if.ready <= 1'b0;
            repeat (hold_off_cycles) @(posedge clock);
            hold_off_cycles = 0;
            rsp_if.ready <= 1'b1;
         end else if (receiver_stalls && $urandom_range(0, 4) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // compare one field; report time, expected and actual on a miss
   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // take each accepted word against the oldest owed one
   always @(posedge clock) begin
      tss_rsp_type w;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_descriptors.size() == 0) begin
            $display("%0t ns: unexpected word, seq %0h next %0h last %0b", $time,
                     rsp_if.seg_seq, rsp_if.updated_next_seq, rsp_if.last);
            mismatches++;
         end else begin
            w = pending_descriptors.pop_front();
            compare_field("seg_valid", w.seg_valid, rsp_if.seg_valid);
            compare_field("seg_seq", w.seg_seq, rsp_if.seg_seq);
            compare_field("seg_ack", w.seg_ack, rsp_if.seg_ack);
            compare_field("seg_flags", w.seg_flags, rsp_if.seg_flags);
            compare_field("payload_start", w.payload_start, rsp_if.payload_start);
            compare_field("payload_bytes", w.payload_bytes, rsp_if.payload_bytes);
            compare_field("window_field", w.window_field, rsp_if.window_field);
            compare_field("updated_next_seq", w.updated_next_seq, rsp_if.updated_next_seq);
            compare_field("updated_max_seq", w.updated_max_seq, rsp_if.updated_max_seq);
            compare_field("last", w.last, rsp_if.last);
         end
      end
   end

   // watchdog: any handshake on any channel counts as progress
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
         $display("%0t ns: no handshake for %0d cycles", $time, STALL_LIMIT);
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // Reset settings: field extremes, every connection state and the corner
   // cases of the sequence and window arithmetic.
   task automatic test_directed_states();
      logic [31:0] base_seq;
      int s;
      // nothing queued, closed: only the bookkeeping word
      send_request(make_request('0, '0, '0, '0, CS_CLOSED, '0, '0, '0, '0));
      // every field at its top; queued length saturates, unknown state
      send_request(make_request('1, '1, '1, 17'h1FFFF, 4'hF, 16'hFFFF, 16'hFFFF, '1,
                                30'h3FFFFFFF));
      // each state with data that ends inside the burst
      for (s = 0; s < 16; s++) begin
         base_seq = $urandom;
         send_request(make_request(base_seq, base_seq, base_seq, 17'd2000, 4'(s), 16'hFFFF,
                                   16'd10, $urandom, 30'($urandom)));
      end
      // send-next behind unacked is pulled forward
      send_request(make_request(32'd1000, 32'd500, 32'd500, 17'd3000, CS_ESTABLISHED,
                                16'hFFFF, 16'd10, 32'd77, 30'd4096));
      // send-max behind send-next is raised
      send_request(make_request(32'd100, 32'd600, 32'd200, 17'd3000, CS_ESTABLISHED,
                                16'hFFFF, 16'd10, 32'd78, 30'd70000));
      // nothing queued in a closing state: a bare FIN goes out
      send_request(make_request(32'd5000, 32'd5000, 32'd5000, '0, CS_FIN_WAIT_1,
                                16'hFFFF, 16'd10, 32'd79, 30'd100));
      // window already used up
      send_request(make_request(32'd0, 32'd14600, 32'd14600, 17'd20000, CS_ESTABLISHED,
                                16'hFFFF, 16'd10, 32'd80, 30'd100));
      // closed peer window with data waiting
      send_request(make_request(32'd0, 32'd0, 32'd0, 17'd3000, CS_CLOSE_WAIT,
                                16'd0, 16'd10, 32'd81, 30'd100));
      // sequence space wraps during the burst
      send_request(make_request(32'hFFFFFF00, 32'hFFFFFF00, 32'hFFFFFF00, 17'd5000,
                                CS_LAST_ACK, 16'hFFFF, 16'd10, 32'd82, 30'd65536));
      quiesce();
   endtask

   // Register extremes: zero segment size, shifts of 15 and 14, largest size.
   task automatic test_register_extremes();
      write_register(CSR_UNUSED, 16'hFFFF);
      configure(16'd0, 4'd15, 4'd15);
      send_request(make_request(32'd0, 32'd0, 32'd0, 17'd3000, CS_ESTABLISHED,
                                16'hFFFF, 16'hFFFF, 32'd1, 30'h3FFFFFFF));
      send_request(make_request(32'd9, 32'd9, 32'd9, '0, CS_CLOSING,
                                16'hFFFF, 16'hFFFF, 32'd2, 30'd65535));
      quiesce();
      configure(16'd1, 4'd15, 4'd14);
      send_request(make_request(32'd40, 32'd40, 32'd40, 17'd5, CS_LAST_ACK,
                                16'd1, 16'd9, 32'd3, 30'h3FFFFFFF));
      send_request(make_request(32'd40, 32'd42, 32'd40, 17'd100, CS_ESTABLISHED,
                                16'hFFFF, 16'd3, 32'd4, 30'd1000000));
      quiesce();
      configure(16'hFFFF, 4'd0, 4'd0);
      send_request(make_request(32'd0, 32'd0, 32'd0, 17'd65536, CS_FIN_WAIT_1,
                                16'hFFFF, 16'd2, 32'd5, 30'd65535));
      send_request(make_request(32'hFFFF0000, 32'hFFFF0000, '0, 17'd131071, CS_ESTABLISHED,
                                16'hFFFF, 16'hFFFF, 32'd6, 30'd65536));
      quiesce();
   endtask

   // Random opportunities under several register settings, idling on.
   task automatic test_random_settings();
      logic [15:0] sizes[5]  = '{16'd1460, 16'd536, 16'd1, 16'd65535, 16'd9000};
      logic [3:0]  sends[5]  = '{4'd0, 4'd2, 4'd14, 4'd15, 4'd7};
      logic [3:0]  recvs[5]  = '{4'd0, 4'd3, 4'd14, 4'd15, 4'd1};
      int p, n;
      for (p = 0; p < 5; p++) begin
         configure(sizes[p], sends[p], recvs[p]);
         for (n = 0; n < 42; n++) send_request(random_opportunity());
         quiesce();
      end
   endtask

   // Hold the output for a long stretch while requests keep coming, so the
   // block backs up and stalls its input.
   task automatic test_receiver_hold_off();
      int n;
      configure(16'd1000, 4'd1, 4'd2);
      hold_off_cycles = 250;
      for (n = 0; n < 30; n++) send_request(random_opportunity());
      quiesce();
   endtask

   // Last stretch with no idling on either side.
   task automatic test_steady_stream();
      int n;
      sender_gaps     = 1'b0;
      receiver_stalls = 1'b0;
      configure(16'd1460, 4'd3, 4'd5);
      for (n = 0; n < 40; n++) send_request(random_opportunity());
      quiesce();
   endtask

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      mismatches      = 0;
      quiet_cycles    = 0;
      hold_off_cycles = 0;
      sender_gaps     = 1'b1;
      receiver_stalls = 1'b1;
      seg_size_reg    = MSS_RESET;
      send_shift_reg  = '0;
      recv_shift_reg  = '0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_directed_states();
      test_register_extremes();
      test_random_settings();
      test_receiver_hold_off();
      test_steady_stream();

      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
